// ===== src/huffman_code_table_decoder_unit_defines.svh =====
// Assertion macros for the prefix-code decoder.
// Every macro samples on clock; the gated forms are muted while reset is high.
`ifndef HUFFMAN_CODE_TABLE_DECODER_UNIT_DEFINES_SVH
`define HUFFMAN_CODE_TABLE_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, muted in reset.
`define HCTD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, muted in reset.
`define HCTD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication, checked through reset as well.
`define HCTD_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/hctd_pkg.sv =====
// ----------------------------------------------------------------------------
// hctd_pkg
// Shared constants and transaction types of the prefix-code decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hctd_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int MAX_CODE_LEN  = 32;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int LEN_W         = 6;
   localparam int CODE_W        = 32;
   localparam int SYM_W         = 8;
   localparam int BYTE_W        = 8;
   localparam int CNT_W         = 32;
   // running length stops at this many bits
   localparam int LEN_LIMIT     = (MAX_CODE_LEN > 63) ? 63 : MAX_CODE_LEN;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_DATA = 1'b1;

   typedef struct packed {
      logic              op;
      logic [7:0]        index;
      logic [SYM_W-1:0]  symbol;
      logic [LEN_W-1:0]  length;
      logic [CODE_W-1:0] code;
      logic [BYTE_W-1:0] data;
   } item_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             code_error;
      logic             last;
   } result_type;

endpackage

`default_nettype wire

// ===== src/hctd_front.sv =====
// ----------------------------------------------------------------------------
// hctd_front
// Input side: takes request transactions into a two-entry queue and drops
// table loads that fall outside the table.
// ----------------------------------------------------------------------------
`default_nettype none

module hctd_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output      logic              full,
   input  wire hctd_pkg::item_type item_in,
   output      logic              item_valid,
   output      hctd_pkg::item_type item_out,
   input  wire logic              item_take
);

   hctd_pkg::item_type q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop, do_store;

   assign full       = (count_ff == 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item_out   = q_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = item_take && item_valid;

   // accept loads aimed past the end of the table but drop them here
   assign do_store   = do_push &&
                       !(item_in.op == hctd_pkg::OP_LOAD &&
                         {1'b0, item_in.index} >= 9'(hctd_pkg::TABLE_ENTRIES));

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_store;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_store} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_store) begin
         q_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/hctd_engine.sv =====
// ----------------------------------------------------------------------------
// hctd_engine
// Back end: code table held as compare cells, bit sequencer, symbol memory,
// one pending result and a two-entry result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hctd_engine (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            item_valid,
   input  wire hctd_pkg::item_type              item,
   output      logic                            item_take,
   input  wire logic [hctd_pkg::CNT_W-1:0]      total_bits,
   input  wire logic                            pop,
   output      logic                            empty,
   output      hctd_pkg::result_type            result
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_BITS  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   localparam int N  = hctd_pkg::TABLE_ENTRIES;
   localparam int CW = hctd_pkg::CODE_W;
   localparam int LW = hctd_pkg::LEN_W;

   // table cells
   logic [CW-1:0]            cell_code_ff [N];
   logic [LW-1:0]            cell_len_ff  [N];
   logic [N-1:0]             cell_valid_ff;
   logic [hctd_pkg::SYM_W-1:0] sym_mem [N];
   logic [hctd_pkg::SYM_W-1:0] sym_q_ff;

   logic [1:0]  state_ff, state_in;
   logic [hctd_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic [3:0]  bit_cnt_ff, bit_cnt_in;
   logic [CW-1:0] rc_ff, rc_in;
   logic [LW-1:0] rl_ff, rl_in;
   logic [hctd_pkg::CNT_W-1:0] used_ff, used_in;
   logic        p_valid_ff, p_valid_in;
   logic        p_err_ff, p_err_in;

   logic [CW-1:0] rc_next, mask;
   logic [LW-1:0] rl_next;
   logic [N-1:0]  hit;
   logic          any_hit, over;
   logic [hctd_pkg::IDX_W-1:0] hit_idx;
   logic          bit_live, step, found, load_wr;

   hctd_pkg::result_type oq_ff [2];
   logic       oq_wp_ff, oq_rp_ff;
   logic [1:0] oq_cnt_ff;
   logic       oq_full, oq_push, oq_pop;
   hctd_pkg::result_type oq_din;

   // next running code and its compare against every cell
   always_comb begin
      rc_next = {rc_ff[CW-2:0], byte_ff[hctd_pkg::BYTE_W-1]};
      rl_next = rl_ff + LW'(1);
      if (rl_next >= LW'(CW)) begin
         mask = '1;
      end else begin
         mask = (CW'(1) << rl_next) - CW'(1);
      end
      for (int i = 0; i < N; i++) begin
         hit[i] = cell_valid_ff[i] && (cell_len_ff[i] == rl_next) &&
                  (((cell_code_ff[i] ^ rc_next) & mask) == '0);
      end
      any_hit = |hit;
      // lowest index wins
      hit_idx = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (hit[i]) begin
            hit_idx = hctd_pkg::IDX_W'(i);
         end
      end
      over = (rl_next >= LW'(hctd_pkg::LEN_LIMIT));
   end

   assign oq_full = (oq_cnt_ff == 2'd2);
   assign empty   = (oq_cnt_ff == 2'd0);
   assign result  = oq_ff[oq_rp_ff];
   assign oq_pop  = pop && !empty;

   always_comb begin
      state_in   = state_ff;
      byte_in    = byte_ff;
      bit_cnt_in = bit_cnt_ff;
      rc_in      = rc_ff;
      rl_in      = rl_ff;
      used_in    = used_ff;
      p_valid_in = p_valid_ff;
      p_err_in   = p_err_ff;
      item_take  = 1'b0;
      load_wr    = 1'b0;
      step       = 1'b0;
      oq_push    = 1'b0;
      oq_din.symbol     = p_err_ff ? '0 : sym_q_ff;
      oq_din.code_error = p_err_ff;
      oq_din.last       = 1'b0;
      bit_live = (bit_cnt_ff != 4'd0) && (used_ff < total_bits);
      found    = any_hit || over;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_take = 1'b1;
               if (item.op == hctd_pkg::OP_LOAD) begin
                  load_wr = 1'b1;
               end else begin
                  byte_in    = item.data;
                  bit_cnt_in = 4'd8;
                  state_in   = ST_BITS;
               end
            end
         end
         ST_BITS: begin
            if (!bit_live) begin
               state_in = ST_FLUSH;
            end else if (!(found && p_valid_ff && oq_full)) begin
               step       = 1'b1;
               used_in    = used_ff + 1'b1;
               bit_cnt_in = bit_cnt_ff - 4'd1;
               byte_in    = {byte_ff[hctd_pkg::BYTE_W-2:0], 1'b0};
               if (found) begin
                  // hand the older result on; it is not the last one
                  oq_push    = p_valid_ff;
                  p_valid_in = 1'b1;
                  p_err_in   = !any_hit;
                  rc_in      = '0;
                  rl_in      = '0;
               end else begin
                  rc_in = rc_next;
                  rl_in = rl_next;
               end
            end
         end
         ST_FLUSH: begin
            if (!p_valid_ff) begin
               state_in = ST_IDLE;
            end else if (!oq_full) begin
               oq_push     = 1'b1;
               oq_din.last = 1'b1;
               p_valid_in  = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bit_cnt_ff    <= 4'd0;
         rc_ff         <= '0;
         rl_ff         <= '0;
         used_ff       <= '0;
         p_valid_ff    <= 1'b0;
         cell_valid_ff <= '0;
         oq_wp_ff      <= 1'b0;
         oq_rp_ff      <= 1'b0;
         oq_cnt_ff     <= 2'd0;
      end else begin
         state_ff   <= state_in;
         bit_cnt_ff <= bit_cnt_in;
         rc_ff      <= rc_in;
         rl_ff      <= rl_in;
         used_ff    <= used_in;
         p_valid_ff <= p_valid_in;
         if (load_wr) begin
            cell_valid_ff[item.index[hctd_pkg::IDX_W-1:0]] <= 1'b1;
         end
         oq_wp_ff  <= oq_wp_ff ^ oq_push;
         oq_rp_ff  <= oq_rp_ff ^ oq_pop;
         oq_cnt_ff <= oq_cnt_ff + {1'b0, oq_push} - {1'b0, oq_pop};
      end
   end

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      p_err_ff <= p_err_in;
      if (load_wr) begin
         cell_code_ff[item.index[hctd_pkg::IDX_W-1:0]] <= item.code;
         cell_len_ff[item.index[hctd_pkg::IDX_W-1:0]]  <= item.length;
      end
      if (oq_push) begin
         oq_ff[oq_wp_ff] <= oq_din;
      end
   end

   // symbol store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (load_wr) begin
         sym_mem[item.index[hctd_pkg::IDX_W-1:0]] <= item.symbol;
      end
      if (step && any_hit) begin
         sym_q_ff <= sym_mem[hit_idx];
      end
   end

endmodule

`default_nettype wire

// ===== src/huffman_code_table_decoder_unit.sv =====
// Prefix-code decoder. A table load is written into the table as it leaves the
// input queue. A data byte enters the sequencer from idle, then steps through
// its meaningful bits (each bit is compared against all table cells at once);
// then the sequencer sees the byte is done and a flush state releases its final
// result, a step spent even when the byte gives no result; a full result queue
// stalls it. The engine takes no new item until the byte is through. The valid
// marks of the table clear at reset.
`default_nettype none

`include "huffman_code_table_decoder_unit_defines.svh"

// ----------------------------------------------------------------------------
// huffman_code_table_decoder_unit
// Top level: input queue, decode engine and configuration register.
// ----------------------------------------------------------------------------
module huffman_code_table_decoder_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output      logic        full,
   input  wire logic        req_op,
   input  wire logic [7:0]  req_entry_index,
   input  wire logic [7:0]  req_entry_symbol,
   input  wire logic [5:0]  req_entry_length,
   input  wire logic [31:0] req_entry_code,
   input  wire logic [7:0]  req_data_byte,
   output      logic        empty,
   input  wire logic        pop,
   output      logic [7:0]  rsp_symbol,
   output      logic        rsp_code_error,
   output      logic        rsp_last,
   input  wire logic        csr_we,
   input  wire logic [31:0] csr_wdata
);

   hctd_pkg::item_type   req_item, q_item;
   hctd_pkg::result_type res;
   logic                 q_valid, q_take;
   logic [31:0]          total_ff;

   always_comb begin
      req_item.op     = req_op;
      req_item.index  = req_entry_index;
      req_item.symbol = req_entry_symbol;
      req_item.length = req_entry_length;
      req_item.code   = req_entry_code;
      req_item.data   = req_data_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (csr_we) begin
         total_ff <= csr_wdata;
      end
   end

   hctd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .item_in    (req_item),
      .item_valid (q_valid),
      .item_out   (q_item),
      .item_take  (q_take)
   );

   hctd_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_valid),
      .item       (q_item),
      .item_take  (q_take),
      .total_bits (total_ff),
      .pop        (pop),
      .empty      (empty),
      .result     (res)
   );

   assign rsp_symbol     = res.symbol;
   assign rsp_code_error = res.code_error;
   assign rsp_last       = res.last;

   `HCTD_ASSERT_NOW(a_err_zero_sym, !empty && rsp_code_error, rsp_symbol == 8'd0, "error result carries a symbol")
   `HCTD_ASSERT_ALWAYS_NEXT(a_reset_clear, reset, empty && !full, "queues not empty after reset")
   `HCTD_ASSERT_NOW(a_full_after_push, $rose(full), $past(push), "queue filled without a push")
   `HCTD_ASSERT_NEXT(a_hold_result, !empty && !pop, !empty && $stable(rsp_symbol) && $stable(rsp_last), "waiting result changed")

endmodule

`default_nettype wire
